// ----- hw/rtl/cia_pkg.sv -----
// Shared types and constants of the circle overlap area block.
// Holds the request, result and classified-item structs and the kind codes.
// No dependencies.
`default_nettype none

package cia_pkg;

   localparam int COORD_BITS  = 16;
   localparam int RADIUS_BITS = 15;
   localparam int AREA_BITS   = 48;
   localparam int RSQ_W       = 2 * RADIUS_BITS;
   localparam int K_W         = 62;
   localparam int CSIG_W      = 35;
   localparam int ROOT_W      = 55;
   localparam int TH_W        = 62;
   localparam int SQ_N        = ROOT_W;
   localparam int CD_N        = 58;
   localparam int Q_DEPTH     = 4;
   localparam int Q_PTR_W     = $clog2(Q_DEPTH);
   localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

   localparam logic [63:0] PI_Q60      = 64'h3243F6A8885A308D;
   localparam logic [63:0] PI_HALF     = PI_Q60 >> 1;
   localparam logic [63:0] PI_QUARTER  = PI_Q60 >> 2;

   localparam logic [1:0] KIND_APART   = 2'd0;
   localparam logic [1:0] KIND_INSIDE  = 2'd1;
   localparam logic [1:0] KIND_PARTIAL = 2'd2;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] center_a_x;
      logic signed [COORD_BITS-1:0] center_a_y;
      logic [RADIUS_BITS-1:0]       radius_a;
      logic signed [COORD_BITS-1:0] center_b_x;
      logic signed [COORD_BITS-1:0] center_b_y;
      logic [RADIUS_BITS-1:0]       radius_b;
   } req_type;

   typedef struct packed {
      logic [AREA_BITS-1:0] overlap_area;
      logic [1:0]           case_kind;
      logic                 saturated;
   } rsp_type;

   // classified request handed from front to back
   typedef struct packed {
      logic [1:0]               kind;
      logic [RSQ_W-1:0]         r1s;
      logic [RSQ_W-1:0]         r2s;
      logic signed [CSIG_W-1:0] c1;
      logic signed [CSIG_W-1:0] c2;
      logic [K_W-1:0]           k;
   } cls_type;

endpackage

`default_nettype wire

// ----- hw/rtl/circle_intersection_area.sv -----
// Overlap area of two circles with integer centers and radii.
//
// Requests enter on req_push/req_full with req_data; a request is taken on a
// clock edge with req_push high and req_full low. Results leave on
// rsp_empty/rsp_pop with rsp_data: the oldest result is shown while rsp_empty
// is low and is taken on an edge with rsp_pop high.
//
// One request per cycle is accepted and one result per cycle delivered while
// the receiver keeps up. A result passes through four classification stages,
// the queue, 55 square root stages (one root bit each), 58 CORDIC stages (one
// angle step each) and five multiply, sum and saturation stages.
//
// When rsp_pop stays low the back pipeline holds, the four-entry queue in the
// middle fills from the front, and req_full rises once the front is blocked.
// Synchronous reset empties all pipelines and the queue; no request is lost
// or invented across a stall.
//
// Depends on cia_pkg, cia_front, cia_queue and cia_back.
`default_nettype none

module circle_intersection_area #(
   parameter int FRAC_BITS = 16
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_push,
   output logic             req_full,
   input  cia_pkg::req_type req_data,
   output logic             rsp_empty,
   input  wire              rsp_pop,
   output cia_pkg::rsp_type rsp_data
);

   logic             cls_push, cls_full, q_pop, q_empty;
   cia_pkg::cls_type cls_data, q_data;

   cia_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .cls_push (cls_push),
      .cls_full (cls_full),
      .cls_data (cls_data)
   );

   cia_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cls_push),
      .push_data (cls_data),
      .full      (cls_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty)
   );

   cia_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/cia_front.sv -----
// Front end: accepts requests, orders radii, squares distances and classifies.
// Four pipeline stages; depends on cia_pkg.
`default_nettype none

module cia_front (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_push,
   output logic             req_full,
   input  cia_pkg::req_type req_data,
   output logic             cls_push,
   input  wire              cls_full,
   output cia_pkg::cls_type cls_data
);

   localparam int CB    = cia_pkg::COORD_BITS;
   localparam int RB    = cia_pkg::RADIUS_BITS;
   localparam int RSQ   = cia_pkg::RSQ_W;
   localparam int D2_W  = 2 * CB + 1;
   localparam int CMP_W = (D2_W > 32) ? D2_W : 32;
   localparam int CS    = cia_pkg::CSIG_W;

   logic [3:0] fv_ff;
   logic       en;

   logic [RB-1:0]  r1_ff, r1_in, r2_ff, r2_in;
   logic [CB-1:0]  dx_ff, dx_in, dy_ff, dy_in;
   logic [2*CB-1:0] dx2_ff, dx2_in, dy2_ff, dy2_in;
   logic [31:0]    sum2_ff, sum2_in;
   logic [RSQ-1:0] dif2_ff, dif2_in, r1s_ff, r1s_in, r2s_ff, r2s_in;
   logic [1:0]     kind_ff, kind_in;
   logic [31:0]    ka_ff, ka_in, kb_ff, kb_in;
   logic [CS-1:0]  c1_ff, c1_in, c2_ff, c2_in;
   logic [RSQ-1:0] r1s3_ff, r2s3_ff;
   cia_pkg::cls_type out_ff, out_in;

   logic [CB:0]    ddx, ddy;
   logic [RB:0]    rsum;
   logic [RB-1:0]  rdif;
   logic [D2_W-1:0] d2;
   logic [63:0]    kprod;

   assign en       = !fv_ff[3] || !cls_full;
   assign req_full = !en;
   assign cls_push = fv_ff[3] && !cls_full;
   assign cls_data = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= '0;
      end else if (en) begin
         fv_ff <= {fv_ff[2:0], req_push};
      end
   end

   // stage 1: order radii, absolute center differences
   always_comb begin
      if (req_data.radius_a < req_data.radius_b) begin
         r1_in = req_data.radius_b;
         r2_in = req_data.radius_a;
      end else begin
         r1_in = req_data.radius_a;
         r2_in = req_data.radius_b;
      end
      ddx = {req_data.center_a_x[CB-1], req_data.center_a_x}
          - {req_data.center_b_x[CB-1], req_data.center_b_x};
      ddy = {req_data.center_a_y[CB-1], req_data.center_a_y}
          - {req_data.center_b_y[CB-1], req_data.center_b_y};
      dx_in = ddx[CB] ? CB'(-ddx) : ddx[CB-1:0];
      dy_in = ddy[CB] ? CB'(-ddy) : ddy[CB-1:0];
   end

   // stage 2: squares
   always_comb begin
      rsum    = {1'b0, r1_ff} + {1'b0, r2_ff};
      rdif    = r1_ff - r2_ff;
      dx2_in  = (2*CB)'(dx_ff) * (2*CB)'(dx_ff);
      dy2_in  = (2*CB)'(dy_ff) * (2*CB)'(dy_ff);
      sum2_in = 32'(rsum) * 32'(rsum);
      dif2_in = RSQ'(rdif) * RSQ'(rdif);
      r1s_in  = RSQ'(r1_ff) * RSQ'(r1_ff);
      r2s_in  = RSQ'(r2_ff) * RSQ'(r2_ff);
   end

   // stage 3: classify, Heron factors and cosine terms
   always_comb begin
      d2 = D2_W'(dx2_ff) + D2_W'(dy2_ff);
      if (CMP_W'(d2) >= CMP_W'(sum2_ff)) begin
         kind_in = cia_pkg::KIND_APART;
      end else if (CMP_W'(d2) <= CMP_W'(dif2_ff)) begin
         kind_in = cia_pkg::KIND_INSIDE;
      end else begin
         kind_in = cia_pkg::KIND_PARTIAL;
      end
      // partial overlap keeps d2 below 2^32, so the low word is enough
      ka_in = d2[31:0] - 32'(dif2_ff);
      kb_in = sum2_ff - d2[31:0];
      c1_in = CS'(d2[31:0]) + CS'(r1s_ff) - CS'(r2s_ff);
      c2_in = CS'(d2[31:0]) + CS'(r2s_ff) - CS'(r1s_ff);
   end

   // stage 4: sixteen times the squared triangle area
   always_comb begin
      kprod      = 64'(ka_ff) * 64'(kb_ff);
      out_in.kind = kind_ff;
      out_in.r1s  = r1s3_ff;
      out_in.r2s  = r2s3_ff;
      out_in.c1   = c1_ff;
      out_in.c2   = c2_ff;
      out_in.k    = kprod[cia_pkg::K_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r1_ff   <= r1_in;
         r2_ff   <= r2_in;
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
         dx2_ff  <= dx2_in;
         dy2_ff  <= dy2_in;
         sum2_ff <= sum2_in;
         dif2_ff <= dif2_in;
         r1s_ff  <= r1s_in;
         r2s_ff  <= r2s_in;
         kind_ff <= kind_in;
         ka_ff   <= ka_in;
         kb_ff   <= kb_in;
         c1_ff   <= c1_in;
         c2_ff   <= c2_in;
         r1s3_ff <= r1s_ff;
         r2s3_ff <= r2s_ff;
         out_ff  <= out_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/cia_queue.sv -----
// Short request queue between the front end and the arithmetic back end.
// Register array with read and write pointers; depends on cia_pkg.
`default_nettype none

module cia_queue (
   input  wire              clock,
   input  wire              reset,
   input  wire              push,
   input  cia_pkg::cls_type push_data,
   output logic             full,
   input  wire              pop,
   output cia_pkg::cls_type pop_data,
   output logic             empty
);

   localparam int PW = cia_pkg::Q_PTR_W;
   localparam int CW = cia_pkg::Q_CNT_W;

   cia_pkg::cls_type mem_ff [cia_pkg::Q_DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full     = (count_ff == CW'(cia_pkg::Q_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in    = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = do_pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(cia_pkg::Q_DEPTH))
      else $error("queue count beyond depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("front pushed into a full queue");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not advance on push");

endmodule

`default_nettype wire

// ----- hw/rtl/cia_back.sv -----
// Back end: pipelined square root, two vectoring CORDIC angle pipelines,
// split multiplies and the final sum with saturation. Depends on cia_pkg.
`default_nettype none

module cia_back #(
   parameter int FRAC_BITS = 16
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              q_empty,
   input  cia_pkg::cls_type q_data,
   output logic             q_pop,
   output logic             rsp_empty,
   input  wire              rsp_pop,
   output cia_pkg::rsp_type rsp_data
);

   localparam int SQ_N   = cia_pkg::SQ_N;
   localparam int CD_N   = cia_pkg::CD_N;
   localparam int RW     = cia_pkg::ROOT_W;
   localparam int RSQ    = cia_pkg::RSQ_W;
   localparam int TW     = cia_pkg::TH_W;
   localparam int CS     = cia_pkg::CSIG_W;
   localparam int KW     = cia_pkg::K_W;
   localparam int AW     = cia_pkg::AREA_BITS;
   localparam int HALF   = 31;
   localparam int PW     = RSQ + HALF;
   localparam int FW     = PW + HALF;
   localparam int SW     = 60;
   localparam int SHIFT  = 60 - FRAC_BITS;
   localparam int QSHIFT = 25 - FRAC_BITS;
   localparam int SEL    = SQ_N + CD_N;
   localparam int NB     = SEL + 5;
   localparam int LAST   = NB - 1;

   typedef struct packed {
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic signed [63:0] z;
   } rot_type;

   typedef struct packed {
      logic [1:0]     kind;
      logic [RSQ-1:0] r1s;
      logic [RSQ-1:0] r2s;
      logic [RW-1:0]  root;
   } tail_type;

   // floor(2^n / m) by shift and subtract, elaboration only
   function automatic logic [63:0] pow2_div(input int n, input int m);
      logic [63:0] q;
      logic [63:0] r;
      int b;
      q = '0;
      r = '0;
      for (b = 63; b >= 0; b--) begin
         r = {r[62:0], (b == n)};
         if (r >= 64'(m)) begin
            r    = r - 64'(m);
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [63:0] atan_step(input int i);
      logic [63:0] sum;
      logic [63:0] term;
      int k;
      int e;
      if (i == 0) begin
         return cia_pkg::PI_QUARTER;
      end
      sum = '0;
      for (k = 0; k < 32; k++) begin
         e = (2 * k + 1) * i;
         if (e <= 60) begin
            term = pow2_div(60 - e, 2 * k + 1);
            if (k[0]) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
      end
      return sum;
   endfunction

   function automatic rot_type rot_step(input rot_type v, input int sh,
                                        input logic [63:0] ang);
      rot_type o;
      logic signed [63:0] dx;
      logic signed [63:0] dy;
      dx = $signed(v.y) >>> sh;
      dy = $signed(v.x) >>> sh;
      if ($signed(v.y) > 64'sd0) begin
         o.x = $signed(v.x) + dx;
         o.y = $signed(v.y) - dy;
         o.z = $signed(v.z) + $signed(ang);
      end else begin
         o.x = $signed(v.x) - dx;
         o.y = $signed(v.y) + dy;
         o.z = $signed(v.z) - $signed(ang);
      end
      return o;
   endfunction

   // turn a vector with negative x by a quarter turn first
   function automatic rot_type rot_init(input logic signed [CS-1:0] c,
                                        input logic [RW-1:0] root);
      rot_type o;
      logic signed [63:0] x0;
      logic signed [63:0] y0;
      x0 = {{(64 - CS - 24){c[CS-1]}}, c, 24'b0};
      y0 = 64'(root);
      if (x0 < 64'sd0) begin
         o.x = y0;
         o.y = -x0;
         o.z = cia_pkg::PI_HALF;
      end else begin
         o.x = x0;
         o.y = y0;
         o.z = '0;
      end
      return o;
   endfunction

   function automatic logic [TW-1:0] clamp_angle(input logic signed [63:0] z);
      logic [TW-1:0] t;
      if (z < 64'sd0) begin
         t = '0;
      end else if (z > $signed(cia_pkg::PI_Q60)) begin
         t = cia_pkg::PI_Q60[TW-1:0];
      end else begin
         t = z[TW-1:0];
      end
      return t;
   endfunction

   logic [NB-1:0] bv_ff;
   logic          en;

   assign en        = !bv_ff[LAST] || rsp_pop;
   assign q_pop     = en && !q_empty;
   assign rsp_empty = !bv_ff[LAST];

   always_ff @(posedge clock) begin
      if (reset) begin
         bv_ff <= '0;
      end else if (en) begin
         bv_ff <= {bv_ff[NB-2:0], !q_empty};
      end
   end

   // square root of k * 2^48, one result bit per stage
   logic [SW-1:0]    sq_rem_ff  [SQ_N];
   logic [RW-1:0]    sq_root_ff [SQ_N];
   cia_pkg::cls_type sq_side_ff [SQ_N];

   for (genvar j = 0; j < SQ_N; j++) begin : g_sq
      logic [SW-1:0]    rem_prev, rem_cat, trial, rem_in;
      logic [RW-1:0]    root_prev, root_in;
      cia_pkg::cls_type side_prev;
      logic [1:0]       pair;
      logic             ge;

      if (j == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign side_prev = q_data;
      end else begin : g_next
         assign rem_prev  = sq_rem_ff[j-1];
         assign root_prev = sq_root_ff[j-1];
         assign side_prev = sq_side_ff[j-1];
      end

      if (KW - 1 - 2 * j >= 1) begin : g_pair
         assign pair = side_prev.k[KW-1-2*j -: 2];
      end else begin : g_zero
         assign pair = 2'b00;
      end

      assign rem_cat = {rem_prev[SW-3:0], pair};
      assign trial   = SW'({root_prev, 2'b01});
      assign ge      = (rem_cat >= trial);
      assign rem_in  = ge ? rem_cat - trial : rem_cat;
      assign root_in = {root_prev[RW-2:0], ge};

      always_ff @(posedge clock) begin
         if (en) begin
            sq_rem_ff[j]  <= rem_in;
            sq_root_ff[j] <= root_in;
            sq_side_ff[j] <= side_prev;
         end
      end
   end

   // half angles at both centers
   rot_type  cr1_ff [CD_N];
   rot_type  cr2_ff [CD_N];
   tail_type ct_ff  [CD_N];

   for (genvar i = 0; i < CD_N; i++) begin : g_cd
      localparam logic [63:0] ANG = atan_step(i);
      rot_type  r1_prev, r2_prev, r1_in, r2_in;
      tail_type t_prev;

      if (i == 0) begin : g_first
         assign r1_prev     = rot_init(sq_side_ff[SQ_N-1].c1, sq_root_ff[SQ_N-1]);
         assign r2_prev     = rot_init(sq_side_ff[SQ_N-1].c2, sq_root_ff[SQ_N-1]);
         assign t_prev.kind = sq_side_ff[SQ_N-1].kind;
         assign t_prev.r1s  = sq_side_ff[SQ_N-1].r1s;
         assign t_prev.r2s  = sq_side_ff[SQ_N-1].r2s;
         assign t_prev.root = sq_root_ff[SQ_N-1];
      end else begin : g_next
         assign r1_prev = cr1_ff[i-1];
         assign r2_prev = cr2_ff[i-1];
         assign t_prev  = ct_ff[i-1];
      end

      assign r1_in = rot_step(r1_prev, i, ANG);
      assign r2_in = rot_step(r2_prev, i, ANG);

      always_ff @(posedge clock) begin
         if (en) begin
            cr1_ff[i] <= r1_in;
            cr2_ff[i] <= r2_in;
            ct_ff[i]  <= t_prev;
         end
      end
   end

   // operand select, split multiplies, sum
   logic [RSQ-1:0] ma1_ff, ma1_in, ma2_ff, ma2_in;
   logic [TW-1:0]  mt1_ff, mt1_in, mt2_ff, mt2_in;
   logic [RW-1:0]  mq_ff, mq_in, pq_ff, nq_ff, uq_ff;
   logic [1:0]     mk_ff, mk_in, pk_ff, nk_ff, uk_ff;
   logic [PW-1:0]  p1l_ff, p1l_in, p1h_ff, p1h_in, p2l_ff, p2l_in, p2h_ff, p2h_in;
   logic [FW-1:0]  full1, full2;
   logic [SW-1:0]  s1_ff, s1_in, s2_ff, s2_in, sum_ff, sum_in, area;
   logic [TW-1:0]  t1, t2;
   logic           sat;
   cia_pkg::rsp_type out_ff, out_in;
   tail_type       tl;

   assign tl = ct_ff[CD_N-1];

   always_comb begin
      t1 = clamp_angle(cr1_ff[CD_N-1].z);
      t2 = clamp_angle(cr2_ff[CD_N-1].z);
      mk_in = tl.kind;
      case (tl.kind)
         cia_pkg::KIND_PARTIAL: begin
            ma1_in = tl.r1s;
            mt1_in = t1;
            ma2_in = tl.r2s;
            mt2_in = t2;
            mq_in  = tl.root >> QSHIFT;
         end
         cia_pkg::KIND_INSIDE: begin
            ma1_in = tl.r2s;
            mt1_in = cia_pkg::PI_Q60[TW-1:0];
            ma2_in = '0;
            mt2_in = '0;
            mq_in  = '0;
         end
         default: begin
            ma1_in = '0;
            mt1_in = '0;
            ma2_in = '0;
            mt2_in = '0;
            mq_in  = '0;
         end
      endcase
   end

   always_comb begin
      p1l_in = PW'(ma1_ff) * PW'(mt1_ff[HALF-1:0]);
      p1h_in = PW'(ma1_ff) * PW'(mt1_ff[TW-1:HALF]);
      p2l_in = PW'(ma2_ff) * PW'(mt2_ff[HALF-1:0]);
      p2h_in = PW'(ma2_ff) * PW'(mt2_ff[TW-1:HALF]);
      full1  = {p1h_ff, {HALF{1'b0}}} + FW'(p1l_ff);
      full2  = {p2h_ff, {HALF{1'b0}}} + FW'(p2l_ff);
      s1_in  = SW'(full1 >> SHIFT);
      s2_in  = SW'(full2 >> SHIFT);
      sum_in = s1_ff + s2_ff;
   end

   // drop below zero, clip at the top of range
   always_comb begin
      area = (sum_ff >= SW'(uq_ff)) ? sum_ff - SW'(uq_ff) : '0;
      sat  = |area[SW-1:AW];
      out_in.overlap_area = sat ? '1 : area[AW-1:0];
      out_in.case_kind    = uk_ff;
      out_in.saturated    = sat;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ma1_ff <= ma1_in;
         mt1_ff <= mt1_in;
         ma2_ff <= ma2_in;
         mt2_ff <= mt2_in;
         mq_ff  <= mq_in;
         mk_ff  <= mk_in;
         p1l_ff <= p1l_in;
         p1h_ff <= p1h_in;
         p2l_ff <= p2l_in;
         p2h_ff <= p2h_in;
         pq_ff  <= mq_ff;
         pk_ff  <= mk_ff;
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         nq_ff  <= pq_ff;
         nk_ff  <= pk_ff;
         sum_ff <= sum_in;
         uq_ff  <= nq_ff;
         uk_ff  <= nk_ff;
         out_ff <= out_in;
      end
   end

   assign rsp_data = out_ff;

endmodule

`default_nettype wire
